[rtl/core/page_allocator_next_fit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the next-fit page allocator
// Shorthand for clocked properties sampled on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef PAGE_ALLOCATOR_NEXT_FIT_ASSERT_SVH
`define PAGE_ALLOCATOR_NEXT_FIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define PANF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define PANF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/panf_pkg.sv]
// ----------------------------------------------------------------------------
// panf_pkg
// Shared constants, codes and controller/datapath interface types of the
// next-fit page allocator.
// ----------------------------------------------------------------------------
package panf_pkg;

  // Table geometry
  localparam int NUM_PAGES  = 1024;
  localparam int PAGE_SHIFT = 12;
  localparam int PAGE_AW    = $clog2(NUM_PAGES);  // page index / tag width
  localparam int CNT_W      = PAGE_AW + 1;        // holds NUM_PAGES itself
  localparam int COUNT_W    = PAGE_AW;            // requested page count
  localparam int PAGES_W    = CNT_W;              // pages_in_use register
  localparam int ADDR_W     = 32;
  localparam int PG_W       = ADDR_W - PAGE_SHIFT;
  localparam int REQ_W      = 2;
  localparam int STAT_W     = 2;
  localparam int CFG_IDX_W  = 1;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_COUNT = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EXHAUSTED = 2'd1;
  localparam logic [STAT_W-1:0] STAT_OUTSIDE   = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGES_IN_USE = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic clear_wr;  // clearing pass: zero one table entry
    logic accept;    // latch a new request
    logic scan;      // issue a table read and evaluate the previous one
    logic mark;      // write one tag of a new block
    logic finish;    // present the result
  } panf_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clear_last;
    logic need_alloc;
    logic need_free;
    logic need_count;
    logic scan_end;
    logic scan_fit;
    logic mark_last;
  } panf_stat_t;

endpackage

[rtl/core/page_allocator_next_fit.sv]
// ----------------------------------------------------------------------------
// page_allocator_next_fit
// Next-fit page allocator with one owner tag per page: allocate, free and
// count requests over a 1024-entry page tag table.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; exactly one result
// follows, shown for a single cycle with done high, and the receiver cannot
// stall it (capture it on that cycle). After reset the block runs a clearing
// pass over the tag memory and stays busy until the pass ends. Requests go one
// at a time through the tag memory, which has one write port and one read
// port; a scan walks one page per cycle. Allocate scans for a free run and
// then marks its pages, free scans and releases the matching pages, count
// scans pages 1 to P-1 (P = effective pages in use), and a request that needs
// no scan goes straight to its result. busy drops in the cycle done is shown,
// so the next request can be issued alongside the result.
// Configuration writes are always ready and belong in idle periods.
// ----------------------------------------------------------------------------
`include "page_allocator_next_fit_assert.svh"

module page_allocator_next_fit import panf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [REQ_W-1:0]     req_type,
  input  logic [COUNT_W-1:0]   page_count,
  input  logic [ADDR_W-1:0]    address,
  output logic                 done,
  output logic [STAT_W-1:0]    status,
  output logic [PAGE_AW-1:0]   start_page,
  output logic [CNT_W-1:0]     page_total,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data
);

  panf_cmd_t  cmd;
  panf_stat_t stat;
  logic [4:0] cmd_vec;

  // Register writes are taken in any cycle
  assign cfg_ready = 1'b1;

  // Sequencer
  panf_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // Tag memory and arithmetic
  panf_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .req_type   (req_type),
    .page_count (page_count),
    .address    (address),
    .done       (done),
    .status     (status),
    .start_page (start_page),
    .page_total (page_total)
  );

  // Checks
  assign cmd_vec = {cmd.clear_wr, cmd.accept, cmd.scan, cmd.mark, cmd.finish};

  `PANF_ASSERT_SAME(a_done_not_busy, done, !busy, "result strobe while busy")
  `PANF_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request left block idle")
  `PANF_ASSERT_SAME(a_cmd_onehot, 1'b1, $onehot0(cmd_vec), "more than one datapath command")
  `PANF_ASSERT_SAME(a_status_code, done, (status == STAT_OK) || (status == STAT_EXHAUSTED) || (status == STAT_OUTSIDE), "undefined status code")

endmodule

[rtl/core/panf_ctrl.sv]
// ----------------------------------------------------------------------------
// panf_ctrl
// Sequencer of the allocator: clearing pass, request decode, table scans,
// tag marking and result hand-off.
// ----------------------------------------------------------------------------
module panf_ctrl import panf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  panf_stat_t stat,
  output panf_cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_ASCAN  = 7'b0000100,
    S_AMARK  = 7'b0001000,
    S_FSCAN  = 7'b0010000,
    S_CSCAN  = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  // Next state and commands
  always_comb begin
    state_next   = state;
    cmd          = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (stat.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          priority if (stat.need_alloc) state_next = S_ASCAN;
          else if (stat.need_free)      state_next = S_FSCAN;
          else if (stat.need_count)     state_next = S_CSCAN;
          else                          state_next = S_FINISH;
        end
      end
      S_ASCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_end) state_next = stat.scan_fit ? S_AMARK : S_FINISH;
      end
      S_AMARK: begin
        cmd.mark = 1'b1;
        if (stat.mark_last) state_next = S_FINISH;
      end
      S_FSCAN, S_CSCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_end) state_next = S_FINISH;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/panf_dp.sv]
// ----------------------------------------------------------------------------
// panf_dp
// Datapath of the allocator: configuration registers, rover, page tag
// memory with a pipelined scan port, run tracking and result registers.
// ----------------------------------------------------------------------------
module panf_dp import panf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  panf_cmd_t            cmd,
  output panf_stat_t           stat,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data,
  input  logic [REQ_W-1:0]     req_type,
  input  logic [COUNT_W-1:0]   page_count,
  input  logic [ADDR_W-1:0]    address,
  output logic                 done,
  output logic [STAT_W-1:0]    status,
  output logic [PAGE_AW-1:0]   start_page,
  output logic [CNT_W-1:0]     page_total
);

  // Configuration and control state
  logic [ADDR_W-1:0]  heap_base;
  logic [PAGES_W-1:0] pages_in_use;
  logic [PAGE_AW-1:0] rover;
  logic [PAGE_AW-1:0] clr_addr;
  logic               chk_vld;

  // Page tag memory
  logic [PAGE_AW-1:0] tags [NUM_PAGES];
  logic [PAGE_AW-1:0] mem_q;
  logic               wr_en;
  logic [PAGE_AW-1:0] wr_addr;
  logic [PAGE_AW-1:0] wr_data;

  // Request working registers
  logic [REQ_W-1:0]   req_q;
  logic [COUNT_W-1:0] need_cnt;
  logic signed [CNT_W:0] limit;
  logic [PAGE_AW-1:0] tag_n;
  logic [CNT_W-1:0]   rd_addr;
  logic [CNT_W-1:0]   chk_addr;
  logic [PAGE_AW-1:0] run_start;
  logic [COUNT_W-1:0] run_len;
  logic [CNT_W-1:0]   mark_addr;
  logic [CNT_W-1:0]   mark_end;
  logic [STAT_W-1:0]  w_status;
  logic [PAGE_AW-1:0] w_start;
  logic [CNT_W-1:0]   w_total;

  // Combinational helpers
  logic [CNT_W-1:0]      p_eff;
  logic signed [CNT_W:0] in_limit;
  logic                  rover_wrap;
  logic [PAGE_AW-1:0]    scan_from;
  logic [ADDR_W-1:0]     off;
  logic [PG_W-1:0]       pg;
  logic [PAGE_AW-1:0]    pg_idx;
  logic                  outside;
  logic                  matchable;
  logic                  pg_free;
  logic                  a_fail;
  logic                  a_fit;
  logic [PAGE_AW-1:0]    fit_start;
  logic                  f_hit;
  logic                  c_match;
  logic                  c_end;

  // Effective page count, clipped to the table depth
  assign p_eff = (pages_in_use > PAGES_W'(NUM_PAGES)) ? PAGES_W'(NUM_PAGES) : pages_in_use;

  // Allocate set-up: scan limit and rover wrap
  assign in_limit   = $signed({1'b0, p_eff}) - $signed({2'b00, page_count});
  assign rover_wrap = $signed({2'b00, rover}) >= in_limit;
  assign scan_from  = rover_wrap ? PAGE_AW'(1) : rover;

  // Address to page translation for free and count
  assign off       = address - heap_base;
  assign pg        = off[ADDR_W-1:PAGE_SHIFT];
  assign pg_idx    = pg[PAGE_AW-1:0];
  assign outside   = (address < heap_base) || (pg >= PG_W'(p_eff));
  assign matchable = (pg != '0) && (off[PAGE_SHIFT-1:0] == '0);

  // Allocate scan: the page under check either opens, extends or breaks a run
  assign pg_free   = (chk_addr != '0) && (mem_q == '0);
  assign a_fail    = chk_vld && (run_len == '0) && ($signed({1'b0, chk_addr}) >= limit);
  assign a_fit     = chk_vld && !a_fail && pg_free && (run_len == COUNT_W'(need_cnt - 1'b1));
  assign fit_start = (run_len == '0) ? chk_addr[PAGE_AW-1:0] : run_start;

  // Free scan: clear while the tag matches and the page is inside the heap
  assign f_hit = chk_vld && (chk_addr < p_eff) && (mem_q == tag_n);

  // Count scan: pages 1 .. P-1
  assign c_match = chk_vld && (mem_q == tag_n);
  assign c_end   = chk_vld && (chk_addr == CNT_W'(p_eff - 1'b1));

  // Status to the controller
  always_comb begin
    stat            = '0;
    stat.clear_last = (clr_addr == PAGE_AW'(NUM_PAGES - 1));
    stat.need_alloc = (req_type == REQ_ALLOC) && (page_count != '0);
    stat.need_free  = (req_type == REQ_FREE) && !outside && matchable;
    stat.need_count = (req_type == REQ_COUNT) && !outside && matchable;
    stat.scan_fit   = a_fit;
    stat.mark_last  = (mark_addr == mark_end);
    unique case (req_q)
      REQ_ALLOC: stat.scan_end = a_fail || a_fit;
      REQ_FREE:  stat.scan_end = chk_vld && !f_hit;
      default:   stat.scan_end = c_end;
    endcase
  end

  // Tag memory write port: clearing pass, block marking, block release
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_addr;
    wr_data = '0;
    priority if (cmd.clear_wr) begin
      wr_en = 1'b1;
    end else if (cmd.mark) begin
      wr_en   = 1'b1;
      wr_addr = mark_addr[PAGE_AW-1:0];
      wr_data = w_start;
    end else if (cmd.scan && (req_q == REQ_FREE) && f_hit) begin
      wr_en   = 1'b1;
      wr_addr = chk_addr[PAGE_AW-1:0];
    end
  end

  // Tag memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) tags[wr_addr] <= wr_data;
    mem_q <= tags[rd_addr[PAGE_AW-1:0]];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base    <= '0;
      pages_in_use <= PAGES_W'(NUM_PAGES);
      rover        <= PAGE_AW'(1);
      clr_addr     <= '0;
      chk_vld      <= 1'b0;
      done         <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == CFG_HEAP_BASE) begin
          heap_base <= cfg_data;
        end else begin
          pages_in_use <= cfg_data[PAGES_W-1:0];
        end
      end
      if (cmd.clear_wr) clr_addr <= clr_addr + PAGE_AW'(1);
      chk_vld <= cmd.scan;
      done    <= cmd.finish;
      // rover moves on wrap, on a successful fit and on every in-heap free
      if (cmd.accept) begin
        if (stat.need_alloc && rover_wrap) rover <= PAGE_AW'(1);
        if ((req_type == REQ_FREE) && !outside) rover <= pg_idx;
      end
      if (cmd.scan && (req_q == REQ_ALLOC) && a_fit) rover <= fit_start;
    end
  end

  // Working and result registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_q    <= req_type;
      need_cnt <= page_count;
      limit    <= in_limit;
      tag_n    <= pg_idx;
      run_len  <= '0;
      w_start  <= '0;
      w_total  <= '0;
      unique case (req_type)
        REQ_ALLOC: begin
          w_status <= STAT_EXHAUSTED;
          rd_addr  <= CNT_W'(scan_from);
        end
        REQ_FREE: begin
          w_status <= outside ? STAT_OUTSIDE : STAT_OK;
          rd_addr  <= CNT_W'(pg_idx);
        end
        REQ_COUNT: begin
          w_status <= outside ? STAT_OUTSIDE : STAT_OK;
          rd_addr  <= CNT_W'(1);
        end
        default: begin
          w_status <= STAT_OK;
        end
      endcase
    end

    // One read issued and one page evaluated per scan cycle
    if (cmd.scan) begin
      rd_addr  <= rd_addr + CNT_W'(1);
      chk_addr <= rd_addr;
      unique case (req_q)
        REQ_ALLOC: begin
          if (chk_vld) begin
            if (pg_free) begin
              if (run_len == '0) run_start <= chk_addr[PAGE_AW-1:0];
              run_len <= run_len + COUNT_W'(1);
            end else begin
              run_len <= '0;
            end
          end
          if (a_fit) begin
            w_status  <= STAT_OK;
            w_start   <= fit_start;
            mark_addr <= CNT_W'(fit_start);
            mark_end  <= CNT_W'(fit_start) + CNT_W'(need_cnt) - CNT_W'(1);
          end
        end
        REQ_FREE: begin
          if (f_hit) w_total <= w_total + CNT_W'(1);
        end
        default: begin
          if (c_match) w_total <= w_total + CNT_W'(1);
        end
      endcase
    end

    if (cmd.mark) mark_addr <= mark_addr + CNT_W'(1);

    if (cmd.finish) begin
      status     <= w_status;
      start_page <= w_start;
      page_total <= w_total;
    end
  end

endmodule
